### rtl/wbps_pkg.sv
package wbps_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_BYTES   = 32;
  localparam int WORD_BYTES  = CFG_DATA_W / BYTE_W;
  localparam int CFG_LEN_W   = 6;
  // effective length, wide enough to hold the largest window depth
  localparam int LEN_W       = 7;
  localparam int CNT_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_A       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_B       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_C       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_D       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WILD_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT = 3'd6;

  localparam logic [CFG_LEN_W-1:0] PAT_LENGTH_RST  = 6'd1;
  localparam logic [CNT_W-1:0]     MATCH_LIMIT_RST = 16'd1;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

### rtl/wbps_in_if.sv
interface wbps_in_if #(
  parameter int ADDRESS_BITS = 48
);
  logic                    valid;
  logic                    ready;
  logic [7:0]              data_byte;
  logic [ADDRESS_BITS-1:0] byte_address;
  logic                    block_start;

  modport source (output valid, data_byte, byte_address, block_start, input ready);
  modport sink   (input valid, data_byte, byte_address, block_start, output ready);
endinterface

### rtl/wbps_out_if.sv
interface wbps_out_if #(
  parameter int ADDRESS_BITS = 48
);
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] match_address;
  logic                    limit_reached;

  modport source (output valid, match_address, limit_reached, input ready);
  modport sink   (input valid, match_address, limit_reached, output ready);
endinterface

### rtl/wbps_cell.sv
module wbps_cell #(
  parameter int MAX_PATTERN = 32,
  parameter int J           = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  wbps_pkg::cell_ctl_t                        ctl_i,
  input  logic [wbps_pkg::BYTE_W-1:0]                byte_i,
  input  logic                                       valid_i,
  input  logic [MAX_PATTERN-1:0][wbps_pkg::BYTE_W-1:0] pat_i,
  input  logic [MAX_PATTERN-1:0]                     wild_i,
  input  logic [wbps_pkg::LEN_W-1:0]                 len_i,
  output logic [wbps_pkg::BYTE_W-1:0]                byte_o,
  output logic                                       valid_o,
  output logic                                       ok_o
);
  import wbps_pkg::*;

  localparam int  IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam bit  FIRST = (J == 0);

  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              valid_q, valid_d;
  logic [LEN_W-1:0]  diff;
  logic [IDX_W-1:0]  idx;
  logic              in_use;

  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (ctl_i.shift) begin
      byte_d  = byte_i;
      // block start empties every older slot, the newest always holds the new byte
      valid_d = FIRST ? valid_i : (valid_i & ~ctl_i.clear);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // this slot lines up with pattern byte len - 1 - J
  assign in_use = (LEN_W'(J) < len_i);
  assign diff   = LEN_W'(len_i - LEN_W'(J) - LEN_W'(1));
  assign idx    = diff[IDX_W-1:0];
  assign ok_o   = !in_use || (valid_d && (wild_i[idx] || (byte_d == pat_i[idx])));

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

### rtl/wbps_out_stage.sv
module wbps_out_stage #(
  parameter int W = 49
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         room_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         ready_i
);
  logic         main_v_q, main_v_d;
  logic         skid_v_q, skid_v_d;
  logic [W-1:0] main_q, main_d;
  logic [W-1:0] skid_q, skid_d;
  logic         pop;

  assign pop = main_v_q & ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (!main_v_q || pop) begin
      main_v_d = push_i;
      main_d   = data_i;
    end else if (push_i) begin
      // head word stalled, park the new one
      skid_v_d = 1'b1;
      skid_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign room_o  = ~skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

endmodule

### rtl/wildcard_byte_pattern_search.sv
// Streaming wildcard pattern search. One addressed byte is taken per clock
// and shifted into a row of MAX_PATTERN window cells; every cell compares its
// byte against the pattern byte it currently lines up with, so each byte is
// checked against the whole pattern in the cycle it arrives. A match word
// (start address of the window, limit flag) is registered in the output
// stage that follows. Sustained rate is one byte per cycle; the input stalls
// only while the two-word output stage is full, which happens after two
// matches are held back by the consumer. A block-start byte empties the
// window, so matches never cross blocks. Pattern, wildcard mask, length and
// match limit must be written through the config port only while the stream
// is idle; the block itself does not enforce this. Once match_limit matches
// are reported, more are dropped until reset or a larger limit is written.
module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN  = 32,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  wbps_in_if.sink                            in_i,
  wbps_out_if.source                         out_o
);
  import wbps_pkg::*;

  localparam int RES_W = ADDRESS_BITS + 1;

  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_word_q;
  logic [PAT_BYTES-1:0]                 wild_q;
  logic [CFG_LEN_W-1:0]                 len_q;
  logic [CNT_W-1:0]                     limit_q;
  logic [CNT_W-1:0]                     cnt_q, cnt_d;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0]   pat;
  logic [MAX_PATTERN-1:0]               wild;
  logic [LEN_W-1:0]                     len_raw, len_eff;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0]   win_byte;
  logic [MAX_PATTERN-1:0]               win_valid;
  logic [MAX_PATTERN-1:0]               ok;
  cell_ctl_t                            ctl;

  logic                    accept, hit, res_valid, room, limit_hit;
  logic [ADDRESS_BITS-1:0] start_addr;
  logic [RES_W-1:0]        res_word;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_word_q <= '0;
      wild_q     <= '0;
      len_q      <= PAT_LENGTH_RST;
      limit_q    <= MATCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_A:       pat_word_q[0] <= cfg_data_i;
        CFG_PAT_B:       pat_word_q[1] <= cfg_data_i;
        CFG_PAT_C:       pat_word_q[2] <= cfg_data_i;
        CFG_PAT_D:       pat_word_q[3] <= cfg_data_i;
        CFG_WILD_MASK:   wild_q        <= cfg_data_i[PAT_BYTES-1:0];
        CFG_PAT_LENGTH:  len_q         <= cfg_data_i[CFG_LEN_W-1:0];
        CFG_MATCH_LIMIT: limit_q       <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pattern positions past the register set are zero and never wild
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < PAT_BYTES) begin : g_reg
      assign pat[k]  = pat_word_q[k / WORD_BYTES][(k % WORD_BYTES) * BYTE_W +: BYTE_W];
      assign wild[k] = wild_q[k];
    end else begin : g_zero
      assign pat[k]  = '0;
      assign wild[k] = 1'b0;
    end
  end

  assign len_raw = LEN_W'(len_q);
  assign len_eff = (len_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_raw;

  assign in_i.ready = room;
  assign accept     = in_i.valid & room;
  assign ctl.shift  = accept;
  assign ctl.clear  = in_i.block_start;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [BYTE_W-1:0] feed_byte;
    logic              feed_valid;
    if (j == 0) begin : g_head
      assign feed_byte  = in_i.data_byte;
      assign feed_valid = 1'b1;
    end else begin : g_link
      assign feed_byte  = win_byte[j-1];
      assign feed_valid = win_valid[j-1];
    end
    wbps_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .J           (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .byte_i  (feed_byte),
      .valid_i (feed_valid),
      .pat_i   (pat),
      .wild_i  (wild),
      .len_i   (len_eff),
      .byte_o  (win_byte[j]),
      .valid_o (win_valid[j]),
      .ok_o    (ok[j])
    );
  end

  assign hit        = accept && (len_eff != '0) && (&ok);
  assign res_valid  = hit && (cnt_q < limit_q);
  assign limit_hit  = (CNT_W'(cnt_q + CNT_W'(1)) == limit_q);
  assign start_addr = ADDRESS_BITS'(in_i.byte_address
                                    - ADDRESS_BITS'(LEN_W'(len_eff - LEN_W'(1))));
  assign res_word   = {start_addr, limit_hit};

  always_comb begin
    cnt_d = cnt_q;
    if (res_valid) begin
      cnt_d = CNT_W'(cnt_q + CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  wbps_out_stage #(
    .W (RES_W)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_word),
    .room_o  (room),
    .valid_o (out_o.valid),
    .data_o  ({out_o.match_address, out_o.limit_reached}),
    .ready_i (out_o.ready)
  );

`ifndef SYNTH
  // a word only enters the output stage when it has space
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> room)
    else $error("match word pushed into full output stage");

  // a match never spans a block boundary
  a_no_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.block_start && (len_eff > LEN_W'(1))) |-> !res_valid)
    else $error("match across block start");

  // the word flagged as last leaves the count at the limit
  a_limit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && limit_hit) |=> (cnt_q == $past(limit_q)))
    else $error("limit flag does not agree with match count");
`endif

endmodule

### verif/wbps_match_checker.sv
`timescale 1ns / 1ps

module wbps_match_checker #(
  parameter int ADDRESS_BITS = 48,
  parameter int WIN_DEPTH    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wbps_in_if                              in_ch,
  wbps_out_if                             out_ch,
  output int                              errors_o,
  output int                              pending_o
);
  import wbps_pkg::*;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] start_addr;
    logic                    at_limit;
  } hit_t;

  hit_t expected_hits[$];

  // shadow of the config registers
  logic [PAT_BYTES*BYTE_W-1:0] pattern;
  logic [PAT_BYTES-1:0]        wild;
  logic [CFG_LEN_W-1:0]        pat_len;
  logic [CNT_W-1:0]            limit;

  // index 0 holds the newest byte
  logic [7:0]       window [WIN_DEPTH];
  int               fill;
  logic [CNT_W-1:0] match_total;
  int               fail_cnt = 0;

  function automatic void scan_byte(input logic [7:0] data,
                                    input logic [ADDRESS_BITS-1:0] addr,
                                    input logic bstart);
    int   eff;
    logic hit;
    hit_t h;
    if (bstart) begin
      for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
      fill = 0;
    end
    for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = data;
    if (fill < WIN_DEPTH) fill++;
    eff = (pat_len > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len);
    if (eff == 0 || fill < eff) return;
    hit = 1'b1;
    // pattern byte k lines up with the byte eff-1-k places back
    for (int k = 0; k < eff; k++) begin
      if (!wild[k] && window[eff-1-k] != pattern[k*8 +: 8]) hit = 1'b0;
    end
    if (!hit || match_total >= limit) return;
    match_total++;
    h.start_addr = addr - ADDRESS_BITS'(eff - 1);
    h.at_limit   = (match_total == limit);
    expected_hits = {expected_hits, h};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t h;
    if (!rst_ni) begin
      pattern     = '0;
      wild        = '0;
      pat_len     = PAT_LENGTH_RST;
      limit       = MATCH_LIMIT_RST;
      for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
      fill        = 0;
      match_total = '0;
      expected_hits.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PAT_A:       pattern[63:0]    = cfg_data_i;
          CFG_PAT_B:       pattern[127:64]  = cfg_data_i;
          CFG_PAT_C:       pattern[191:128] = cfg_data_i;
          CFG_PAT_D:       pattern[255:192] = cfg_data_i;
          CFG_WILD_MASK:   wild             = cfg_data_i[PAT_BYTES-1:0];
          CFG_PAT_LENGTH:  pat_len          = cfg_data_i[CFG_LEN_W-1:0];
          CFG_MATCH_LIMIT: limit            = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected match word: got address %h limit %b",
                   $time, out_ch.match_address, out_ch.limit_reached);
        end else begin
          h = expected_hits.pop_front();
          if (out_ch.match_address !== h.start_addr ||
              out_ch.limit_reached !== h.at_limit) begin
            fail_cnt++;
            $display("%0t: mismatch: expected addr %h lim %b, got addr %h lim %b",
                     $time, h.start_addr, h.at_limit,
                     out_ch.match_address, out_ch.limit_reached);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        scan_byte(in_ch.data_byte, in_ch.byte_address, in_ch.block_start);
    end
    errors_o  <= fail_cnt;
    pending_o <= expected_hits.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import wbps_pkg::*;

  localparam int ADDR_W     = 48;
  localparam int WIN        = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 8;

  typedef struct packed {
    logic [PAT_BYTES*BYTE_W-1:0] pattern;
    logic [PAT_BYTES-1:0]        wild;
    logic [CFG_LEN_W-1:0]        len;
    logic [CNT_W-1:0]            limit;
  } scan_cfg_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wbps_in_if  #(.ADDRESS_BITS(ADDR_W)) in_ch ();
  wbps_out_if #(.ADDRESS_BITS(ADDR_W)) out_ch ();

  int          src_idle_pct;
  int          sink_idle_pct;
  int          idle_cycles = 0;
  int          words_out = 0;
  int          errors;
  int          pending;
  scan_cfg_t   cur_cfg;
  logic [ADDR_W-1:0] next_addr;

  wildcard_byte_pattern_search #(
    .MAX_PATTERN (WIN),
    .ADDRESS_BITS(ADDR_W)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  wbps_match_checker #(
    .ADDRESS_BITS(ADDR_W),
    .WIN_DEPTH   (WIN)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog: cycles with no handshake and no register write
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) words_out <= words_out + 1;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("wildcard_byte_pattern_search regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_cfg(input scan_cfg_t c);
    write_reg(CFG_PAT_A, c.pattern[63:0]);
    write_reg(CFG_PAT_B, c.pattern[127:64]);
    write_reg(CFG_PAT_C, c.pattern[191:128]);
    write_reg(CFG_PAT_D, c.pattern[255:192]);
    write_reg(CFG_WILD_MASK, CFG_DATA_W'(c.wild));
    write_reg(CFG_PAT_LENGTH, CFG_DATA_W'(c.len));
    write_reg(CFG_MATCH_LIMIT, CFG_DATA_W'(c.limit));
    cfg_we  <= 1'b0;
    cur_cfg  = c;
  endtask

  // one byte at next_addr, which then advances
  task automatic send_byte(input logic [7:0] d, input logic bs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= d;
    in_ch.byte_address <= next_addr;
    in_ch.block_start  <= bs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    next_addr = next_addr + 1'b1;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic new_block_addr();
    logic [63:0] r;
    int pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 20) next_addr = '1 - ADDR_W'($urandom_range(40));
    else if (pick < 25) next_addr = '0;
    else next_addr = r[ADDR_W-1:0];
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int eff;
    int bad;
    int run;
    logic [7:0] b;
    sent = 0;
    eff  = (cur_cfg.len == 0) ? 4 : (cur_cfg.len > WIN) ? WIN : int'(cur_cfg.len);
    new_block_addr();
    send_byte(8'($urandom), 1'b1);
    while (sent < n_items) begin
      case ($urandom_range(99)) inside
        [0:64]: begin
          // planted occurrence, sometimes with one byte spoiled
          bad = ($urandom_range(99) < 15) ? $urandom_range(eff - 1) : -1;
          for (int pos = 0; pos < eff; pos++) begin
            if (pos == bad || cur_cfg.wild[pos]) b = 8'($urandom);
            else b = cur_cfg.pattern[pos*8 +: 8];
            send_byte(b, 1'b0);
            sent++;
          end
        end
        [65:89]: begin
          run = $urandom_range(1, 6);
          repeat (run) begin
            if ($urandom_range(1) == 1) b = 8'($urandom);
            else b = cur_cfg.pattern[$urandom_range(eff - 1)*8 +: 8];
            send_byte(b, 1'b0);
            sent++;
          end
        end
        default: begin
          new_block_addr();
          send_byte(8'($urandom), 1'b1);
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    scan_cfg_t c;
    int items;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_address = '0;
    in_ch.block_start  = 1'b0;
    src_idle_pct       = 11;
    sink_idle_pct      = 84;
    next_addr          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: one zero byte, limit of one
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    drain();

    // four bytes with byte 2 wild; first hit wraps below address zero
    c         = '0;
    c.pattern = {224'h0, 32'h4433_2211};
    c.wild    = 32'h0000_0004;
    c.len     = 6'd4;
    c.limit   = 16'hFFFF;
    load_cfg(c);
    next_addr = '1 - 1'b1;
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h44, 1'b0);
    // block start in the middle kills the match
    next_addr = 48'h10;
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h44, 1'b0);
    next_addr = 48'h30;
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    drain();

    // zero length never matches
    c.len = 6'd0;
    load_cfg(c);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    drain();

    // zero limit suppresses everything
    c.len   = 6'd4;
    c.limit = 16'h0000;
    load_cfg(c);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        src_idle_pct  = 11;
        sink_idle_pct = 84;
      end else if (ph < 7) begin
        src_idle_pct  = 84;
        sink_idle_pct = 11;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      for (int w = 0; w < PAT_BYTES * BYTE_W / 32; w++) c.pattern[w*32 +: 32] = $urandom;
      c.wild  = $urandom & $urandom & $urandom;
      c.len   = 6'($urandom_range(1, 6));
      c.limit = 16'hFFFF;
      items   = 210;
      case (ph)
        1: c.len = 6'd32;
        2: begin
          c.len  = 6'($urandom_range(33, 63));
          c.wild = $urandom | $urandom;
        end
        // limit reached a few matches in, then silence
        3: c.limit = 16'(words_out + $urandom_range(1, 3));
        4: begin
          c.len = 6'd0;
          items = 40;
        end
        5: begin
          c.limit = 16'h0000;
          items   = 40;
        end
        6: begin
          c.pattern = '1;
          c.wild    = '0;
          c.len     = 6'd3;
        end
        7: begin
          c.wild = '1;
          c.len  = 6'd5;
        end
        default: c.len = 6'($urandom_range(1, 12));
      endcase
      load_cfg(c);
      run_phase(items);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("wildcard_byte_pattern_search regression: pass");
    end else begin
      $display("wildcard_byte_pattern_search regression: fail");
    end
    $finish;
  end

endmodule
